[hw/rtl/touch_joystick_vector_assert.svh]
// assertion macros shared by the joystick vector rtl
`ifndef TOUCH_JOYSTICK_VECTOR_ASSERT_SVH
`define TOUCH_JOYSTICK_VECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TJV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TJV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TJV_ASSERT_NOW(label, ante, cons, msg)
`define TJV_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/tjv_pkg.sv]
// types and constants of the touch joystick vector block
`default_nettype none
package tjv_pkg;
  localparam int TJV_COORD_BITS = 12;
  localparam int TJV_IN_BITS    = 12;
  localparam int TJV_MUL_W      = 26;
  localparam int TJV_Q_BITS     = 16;
  localparam int TJV_ROOT_BITS  = 12;
  localparam logic [3:0] TJV_ROOT_MSB = 4'd11;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_MAX_TRAVEL  = 3'd2;
  localparam logic [2:0] REG_KNOB_RADIUS = 3'd3;
  localparam logic [2:0] REG_STICK_ID    = 3'd4;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_DRAG    = 2'd1,
    EV_RELEASE = 2'd2,
    EV_OTHER   = 2'd3
  } tjv_event_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_MSQ,
    ST_RHSX,
    ST_RHSY,
    ST_CINIT,
    ST_CMUL,
    ST_CCMP,
    ST_RSQ,
    ST_GRAB,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } tjv_state_t;

  typedef struct packed {
    logic       in_fire;
    tjv_event_t in_kind;
    logic       is_press;
    logic       dragging;
    logic       clamp;
    logic       small_move;
    logic       div_done;
    logic       out_free;
  } tjv_stat_t;

  typedef struct packed {
    tjv_state_t state;
    logic       comp_y;
    logic [3:0] bit_idx;
    logic       in_ready;
    logic       div_start;
    logic       out_load;
  } tjv_ctrl_t;
endpackage
`default_nettype wire

[hw/rtl/touch_joystick_vector.sv]
// on-screen joystick: touch events in, clamped knob offset and q1.15 ratios out
//
// in_*  : one word per touch event; tuser carries the event kind, tdata the point.
// out_* : zero or one report word per event (release always reports, a press
//         never does, a drag reports when grabbed and the move is not tiny).
// cfg_* : register writes, always ready; write only while no event is in work.
// in_tready is low while an event is in work. With clamping, the root search
// steps each bit through a multiply state and a compare state, twelve bits
// per axis on the shared multiplier. The two q1.15 ratios come from a
// two-lane divider, one bit per cycle, 16 quotient bits per ratio.
// The report sits in an output register: the next event is accepted while it
// waits; if the receiver still stalls when a new report is ready, the block
// holds in its emit step until out_tready frees the register.
// Reset clears the grab flag, the output valid and the registers (max travel
// to 1, the rest to 0). A max travel of 0 acts as 1.
`default_nettype none
`include "touch_joystick_vector_assert.svh"
module touch_joystick_vector #(
  parameter int COORD_BITS = tjv_pkg::TJV_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // touch_x[11:0], touch_y[23:12]
  input  logic [1:0]  in_tuser,   // event_kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // report_id[7:0], ratio_x[23:8], ratio_y[39:24],
                                  // knob_x[51:40], knob_y[63:52]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import tjv_pkg::*;

  localparam int CW = (COORD_BITS < TJV_IN_BITS) ? COORD_BITS : TJV_IN_BITS;
  localparam logic [TJV_IN_BITS-1:0] CMASK = TJV_IN_BITS'((64'd1 << CW) - 64'd1);

  tjv_ctrl_t ctrl;
  tjv_stat_t stat;

  // registers
  logic [11:0] center_x_r, center_y_r;
  logic [10:0] max_travel_r, knob_radius_r;
  logic [7:0]  stick_id_r;
  logic [10:0] m_eff;

  // event state
  logic        dragging_r, is_press_r, zero_r, clamp_r, sx_r, sy_r;
  logic [11:0] ax_r, ay_r, kmx_r, kmy_r, q_r;
  logic [23:0] ax2_r, ay2_r, qsq_r, csq_r, kysq_r;
  logic [25:0] len2_r, k2_r;
  logic [21:0] msq_r;
  logic [45:0] rhsx_r, rhsy_r;
  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;

  logic [25:0] mul_a, mul_b;
  logic [51:0] mul_p;

  logic        div_done;
  logic [15:0] div_qx, div_qy;

  logic        in_fire;
  logic [11:0] tx, ty, cx, cy;
  logic [12:0] dx, dy, dx_neg, dy_neg;
  logic [11:0] ax_nxt, ay_nxt;

  logic [11:0] c_bit, c_val, q_new;
  logic [45:0] rhs_sel;
  logic        bit_ok;
  logic [23:0] qsq_new, csq_step;
  logic [4:0]  sq_shift;
  logic        clamp_now;

  logic [21:0] r2;
  logic [25:0] nine_r2;
  logic [27:0] four_k2;
  logic        grab;

  logic [18:0] hx, hy;
  logic        small_move;

  logic [11:0] knob_x, knob_y;
  logic [15:0] ratio_x, ratio_y;

  function automatic logic [15:0] q15_sat(input logic [15:0] mag, input logic neg);
    logic [15:0] r;
    if (neg) begin
      r = 16'd0 - mag;
    end else if (mag[15]) begin
      r = 16'h7fff;
    end else begin
      r = mag;
    end
    return r;
  endfunction

  assign m_eff     = (max_travel_r == 11'd0) ? 11'd1 : max_travel_r;
  assign cfg_ready = 1'b1;
  assign in_tready = ctrl.in_ready;
  assign in_fire   = in_tvalid && in_tready;

  // offsets from the center at acceptance
  always_comb begin
    tx     = in_tdata[11:0] & CMASK;
    ty     = in_tdata[23:12] & CMASK;
    cx     = center_x_r & CMASK;
    cy     = center_y_r & CMASK;
    dx     = {1'b0, tx} - {1'b0, cx};
    dy     = {1'b0, ty} - {1'b0, cy};
    dx_neg = 13'd0 - dx;
    dy_neg = 13'd0 - dy;
    ax_nxt = dx[12] ? dx_neg[11:0] : dx[11:0];
    ay_nxt = dy[12] ? dy_neg[11:0] : dy[11:0];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.state)
      ST_SQX: begin
        mul_a = {14'd0, ax_r};
        mul_b = {14'd0, ax_r};
      end
      ST_SQY: begin
        mul_a = {14'd0, ay_r};
        mul_b = {14'd0, ay_r};
      end
      ST_MSQ: begin
        mul_a = {15'd0, m_eff};
        mul_b = {15'd0, m_eff};
      end
      ST_RHSX: begin
        mul_a = {4'd0, mul_p[21:0]};
        mul_b = {2'd0, ax2_r};
      end
      ST_RHSY: begin
        mul_a = {4'd0, msq_r};
        mul_b = {2'd0, ay2_r};
      end
      ST_CMUL: begin
        mul_a = {2'd0, csq_r};
        mul_b = len2_r;
      end
      ST_RSQ: begin
        mul_a = {15'd0, knob_radius_r};
        mul_b = {15'd0, knob_radius_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // root search bit: largest q <= m with q^2 * len2 <= m^2 * a^2
  always_comb begin
    c_bit     = 12'd1 << ctrl.bit_idx;
    c_val     = q_r | c_bit;
    rhs_sel   = ctrl.comp_y ? rhsy_r : rhsx_r;
    bit_ok    = (mul_p <= {6'd0, rhs_sel}) && (c_val <= {1'b0, m_eff});
    q_new     = bit_ok ? c_val : q_r;
    qsq_new   = bit_ok ? csq_r : qsq_r;
    // square of the next candidate from the running square
    sq_shift  = {ctrl.bit_idx, 1'b0} - 5'd2;
    csq_step  = qsq_new + ({12'd0, q_new} << ctrl.bit_idx) + (24'd1 << sq_shift);
    clamp_now = len2_r > {4'd0, mul_p[21:0]};
  end

  // grab zone: 4*k^2 <= 9*r^2
  always_comb begin
    r2      = mul_p[21:0];
    nine_r2 = {1'b0, r2, 3'b000} + {4'd0, r2};
    four_k2 = {k2_r, 2'b00};
    grab    = four_k2 <= {2'd0, nine_r2};
  end

  always_comb begin
    hx         = {7'd0, kmx_r} * 19'd100;
    hy         = {7'd0, kmy_r} * 19'd100;
    small_move = (hx < {8'd0, m_eff}) && (hy < {8'd0, m_eff});
  end

  always_comb begin
    knob_x  = sx_r ? 12'd0 - kmx_r : kmx_r;
    knob_y  = sy_r ? 12'd0 - kmy_r : kmy_r;
    ratio_x = q15_sat(div_qx, sx_r);
    ratio_y = q15_sat(div_qy, !sy_r);
  end

  always_comb begin
    stat.in_fire    = in_fire;
    stat.in_kind    = tjv_event_t'(in_tuser);
    stat.is_press   = is_press_r;
    stat.dragging   = dragging_r;
    stat.clamp      = clamp_now;
    stat.small_move = small_move;
    stat.div_done   = div_done;
    stat.out_free   = !out_tvalid_r || out_tready;
  end

  tjv_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  tjv_mul #(
    .W (TJV_MUL_W)
  ) u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  tjv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (ctrl.div_start),
    .m_i     (m_eff),
    .a0_i    (kmx_r),
    .a1_i    (kmy_r),
    .done_o  (div_done),
    .q0_o    (div_qx),
    .q1_o    (div_qy)
  );

  // control state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      max_travel_r  <= 11'd1;
      knob_radius_r <= '0;
      stick_id_r    <= '0;
      dragging_r    <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        priority case (cfg_index)
          REG_CENTER_X:    center_x_r    <= cfg_data;
          REG_CENTER_Y:    center_y_r    <= cfg_data;
          REG_MAX_TRAVEL:  max_travel_r  <= cfg_data[10:0];
          REG_KNOB_RADIUS: knob_radius_r <= cfg_data[10:0];
          REG_STICK_ID:    stick_id_r    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_fire && (tjv_event_t'(in_tuser) == EV_RELEASE)) begin
        dragging_r <= 1'b0;
      end else if (ctrl.state == ST_GRAB) begin
        dragging_r <= grab;
      end
      if (ctrl.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (ctrl.state)
      ST_IDLE: begin
        if (in_fire) begin
          is_press_r <= (tjv_event_t'(in_tuser) == EV_PRESS);
          zero_r     <= (tjv_event_t'(in_tuser) == EV_RELEASE);
          sx_r       <= dx[12];
          sy_r       <= dy[12];
          ax_r       <= ax_nxt;
          ay_r       <= ay_nxt;
        end
      end
      ST_SQY: ax2_r <= mul_p[23:0];
      ST_MSQ: begin
        ay2_r  <= mul_p[23:0];
        len2_r <= {2'd0, ax2_r} + {2'd0, mul_p[23:0]};
      end
      ST_RHSX: begin
        msq_r   <= mul_p[21:0];
        clamp_r <= clamp_now;
        k2_r    <= len2_r;
        kmx_r   <= ax_r;
        kmy_r   <= ay_r;
      end
      ST_RHSY: rhsx_r <= mul_p[45:0];
      ST_CINIT: begin
        rhsy_r <= mul_p[45:0];
        q_r    <= '0;
        qsq_r  <= '0;
        csq_r  <= 24'd1 << (2 * (TJV_ROOT_BITS - 1));
      end
      ST_CCMP: begin
        if (ctrl.bit_idx == 4'd0) begin
          q_r   <= '0;
          qsq_r <= '0;
          csq_r <= 24'd1 << (2 * (TJV_ROOT_BITS - 1));
          if (!ctrl.comp_y) begin
            kmx_r <= q_new;
            k2_r  <= {2'd0, qsq_new};
          end else begin
            kmy_r  <= q_new;
            kysq_r <= qsq_new;
          end
        end else begin
          q_r   <= q_new;
          qsq_r <= qsq_new;
          csq_r <= csq_step;
        end
      end
      ST_RSQ: begin
        if (clamp_r) begin
          k2_r <= k2_r + {2'd0, kysq_r};
        end
      end
      ST_EMIT: begin
        if (ctrl.out_load) begin
          if (zero_r) begin
            out_tdata_r <= {56'd0, stick_id_r};
          end else begin
            out_tdata_r <= {knob_y, knob_x, ratio_y, ratio_x, stick_id_r};
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `TJV_ASSERT_NOW(a_knob_in_travel, ctrl.out_load && !zero_r, (kmx_r <= {1'b0, m_eff}) && (kmy_r <= {1'b0, m_eff}), "knob offset beyond travel")
  `TJV_ASSERT_NOW(a_clamp_shrinks, ctrl.state == ST_DIV_START, (kmx_r <= ax_r) && (kmy_r <= ay_r), "clamp grew the offset")
  `TJV_ASSERT_NOW(a_div_done_wait, div_done, ctrl.state == ST_DIV_WAIT, "divider done outside wait")
  `TJV_ASSERT_NEXT(a_release_drops, in_fire && (in_tuser == EV_RELEASE), !dragging_r, "release kept grab")
endmodule
`default_nettype wire

[hw/rtl/tjv_mul.sv]
// shared unsigned multiplier with registered product
`default_nettype none
module tjv_mul #(
  parameter int W = tjv_pkg::TJV_MUL_W
) (
  input  logic           clk,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);
  logic [2*W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a_i * b_i;
  end

  assign p_o = p_r;
endmodule
`default_nettype wire

[hw/rtl/tjv_div.sv]
// two-lane restoring divider, one quotient bit per cycle: a * 2^15 / m
`default_nettype none
module tjv_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [10:0] m_i,
  input  logic [11:0] a0_i,
  input  logic [11:0] a1_i,
  output logic        done_o,
  output logic [15:0] q0_o,
  output logic [15:0] q1_o
);
  import tjv_pkg::*;

  localparam logic [4:0] STEPS = 5'(TJV_Q_BITS);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [10:0] m_r;
  logic [11:0] rem0_r, rem1_r;
  logic [15:0] q0_r, q1_r;

  logic        ge0, ge1;
  logic [11:0] sub0, sub1;

  // remainder stays below twice the divisor, so one compare-subtract per bit
  always_comb begin
    ge0  = rem0_r >= {1'b0, m_r};
    ge1  = rem1_r >= {1'b0, m_r};
    sub0 = ge0 ? rem0_r - {1'b0, m_r} : rem0_r;
    sub1 = ge1 ? rem1_r - {1'b0, m_r} : rem1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      m_r    <= m_i;
      rem0_r <= a0_i;
      rem1_r <= a1_i;
      q0_r   <= '0;
      q1_r   <= '0;
    end else if (busy_r) begin
      rem0_r <= {sub0[10:0], 1'b0};
      rem1_r <= {sub1[10:0], 1'b0};
      q0_r   <= {q0_r[14:0], ge0};
      q1_r   <= {q1_r[14:0], ge1};
    end
  end

  assign done_o = done_r;
  assign q0_o   = q0_r;
  assign q1_o   = q1_r;
endmodule
`default_nettype wire

[hw/rtl/tjv_ctrl.sv]
// sequencer stepping the shared multiplier, the root search and the divider
`default_nettype none
module tjv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  tjv_pkg::tjv_stat_t stat_i,
  output tjv_pkg::tjv_ctrl_t ctrl_o
);
  import tjv_pkg::*;

  tjv_state_t state_r, state_nxt;
  logic       comp_r, comp_nxt;
  logic [3:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      comp_r  <= 1'b0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (stat_i.in_fire) begin
          unique case (stat_i.in_kind)
            EV_PRESS:   state_nxt = ST_SQX;
            EV_DRAG:    state_nxt = stat_i.dragging ? ST_SQX : ST_IDLE;
            EV_RELEASE: state_nxt = ST_EMIT;
            EV_OTHER:   state_nxt = ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_MSQ;
      ST_MSQ:  state_nxt = ST_RHSX;
      ST_RHSX: begin
        if (stat_i.clamp) begin
          state_nxt = ST_RHSY;
        end else begin
          state_nxt = stat_i.is_press ? ST_RSQ : ST_DIV_START;
        end
      end
      ST_RHSY: state_nxt = ST_CINIT;
      ST_CINIT: begin
        state_nxt = ST_CMUL;
        comp_nxt  = 1'b0;
        bit_nxt   = TJV_ROOT_MSB;
      end
      ST_CMUL: state_nxt = ST_CCMP;
      ST_CCMP: begin
        if (bit_r == 4'd0) begin
          if (!comp_r) begin
            state_nxt = ST_CMUL;
            comp_nxt  = 1'b1;
            bit_nxt   = TJV_ROOT_MSB;
          end else begin
            state_nxt = stat_i.is_press ? ST_RSQ : ST_DIV_START;
          end
        end else begin
          state_nxt = ST_CMUL;
          bit_nxt   = bit_r - 4'd1;
        end
      end
      ST_RSQ:       state_nxt = ST_GRAB;
      ST_GRAB:      state_nxt = ST_IDLE;
      ST_DIV_START: state_nxt = stat_i.small_move ? ST_IDLE : ST_DIV_WAIT;
      ST_DIV_WAIT:  state_nxt = stat_i.div_done ? ST_EMIT : ST_DIV_WAIT;
      ST_EMIT:      state_nxt = stat_i.out_free ? ST_IDLE : ST_EMIT;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o.state     = state_r;
    ctrl_o.comp_y    = comp_r;
    ctrl_o.bit_idx   = bit_r;
    ctrl_o.in_ready  = (state_r == ST_IDLE);
    ctrl_o.div_start = (state_r == ST_DIV_START) && !stat_i.small_move;
    ctrl_o.out_load  = (state_r == ST_EMIT) && stat_i.out_free;
  end
endmodule
`default_nettype wire

[tb/touch_joystick_vector_checker.sv]
`timescale 1ns / 100ps
// watches the joystick channels, predicts each report word and compares it
module touch_joystick_vector_checker
  import tjv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [11:0] knob_y;
    logic [11:0] knob_x;
    logic [15:0] ratio_y;
    logic [15:0] ratio_x;
    logic [7:0]  id;
  } joy_report_t;

  joy_report_t report_q[$];

  logic [11:0] ctr_x;
  logic [11:0] ctr_y;
  logic [10:0] travel;
  logic [10:0] knob_r;
  logic [7:0]  stick;
  logic        knob_held;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  // floor(m * |d| / sqrt(len2)) found bit by bit, sign of d restored
  function automatic longint clamp_axis(input longint d, input longint m, input longint len2);
    longint a;
    longint rhs;
    longint q;
    longint c;
    int     b;
    a   = (d < 0) ? -d : d;
    rhs = m * m * a * a;
    q   = 0;
    for (b = 11; b >= 0; b--) begin
      c = q | (longint'(1) << b);
      if (c <= m && c * c * len2 <= rhs) q = c;
    end
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] ratio_q15(input longint k, input longint m);
    longint a;
    longint r;
    a = (k < 0) ? -k : k;
    r = (a * 32768) / m;
    if (k < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic bit predict_report(input tjv_event_t kind, input logic [11:0] tx,
                                        input logic [11:0] ty, output joy_report_t rep);
    longint m;
    longint dx;
    longint dy;
    longint kx;
    longint ky;
    longint len2;
    longint ax;
    longint ay;
    rep    = '0;
    rep.id = stick;
    m = (travel == '0) ? 1 : longint'(travel);
    if (kind == EV_OTHER) return 1'b0;
    if (kind == EV_RELEASE) begin
      knob_held = 1'b0;
      return 1'b1;
    end
    if (kind == EV_DRAG && !knob_held) return 1'b0;
    dx   = longint'(tx) - longint'(ctr_x);
    dy   = longint'(ty) - longint'(ctr_y);
    len2 = dx * dx + dy * dy;
    kx   = dx;
    ky   = dy;
    if (len2 > m * m) begin
      kx = clamp_axis(dx, m, len2);
      ky = clamp_axis(dy, m, len2);
    end
    if (kind == EV_PRESS) begin
      // grab zone is one and a half knob radii
      knob_held = (4 * (kx * kx + ky * ky)) <= (9 * longint'(knob_r) * longint'(knob_r));
      return 1'b0;
    end
    ax = (kx < 0) ? -kx : kx;
    ay = (ky < 0) ? -ky : ky;
    if (100 * ax < m && 100 * ay < m) return 1'b0;
    rep.ratio_x = ratio_q15(kx, m);
    rep.ratio_y = ratio_q15(-ky, m);
    rep.knob_x  = kx[11:0];
    rep.knob_y  = ky[11:0];
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    joy_report_t want;
    joy_report_t got;
    if (!rst_n) begin
      ctr_x     = '0;
      ctr_y     = '0;
      travel    = 11'd1;
      knob_r    = '0;
      stick     = '0;
      knob_held = 1'b0;
      report_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X:    ctr_x  = cfg_data;
          REG_CENTER_Y:    ctr_y  = cfg_data;
          REG_MAX_TRAVEL:  travel = cfg_data[10:0];
          REG_KNOB_RADIUS: knob_r = cfg_data[10:0];
          REG_STICK_ID:    stick  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (report_q.size() == 0) begin
          report_mismatch($sformatf("report word %h with none expected", out_tdata));
        end else begin
          want = report_q.pop_front();
          if (got.id !== want.id)
            report_mismatch($sformatf("report_id got %0d expected %0d", got.id, want.id));
          if (got.ratio_x !== want.ratio_x)
            report_mismatch($sformatf("ratio_x got %0d expected %0d",
                                      $signed(got.ratio_x), $signed(want.ratio_x)));
          if (got.ratio_y !== want.ratio_y)
            report_mismatch($sformatf("ratio_y got %0d expected %0d",
                                      $signed(got.ratio_y), $signed(want.ratio_y)));
          if (got.knob_x !== want.knob_x)
            report_mismatch($sformatf("knob_x got %0d expected %0d",
                                      $signed(got.knob_x), $signed(want.knob_x)));
          if (got.knob_y !== want.knob_y)
            report_mismatch($sformatf("knob_y got %0d expected %0d",
                                      $signed(got.knob_y), $signed(want.knob_y)));
        end
      end
      if (in_tvalid && in_tready) begin
        if (predict_report(tjv_event_t'(in_tuser), in_tdata[11:0], in_tdata[23:12], want))
          report_q.push_back(want);
      end
    end
    pending = report_q.size();
  end

endmodule

[tb/tb_touch_joystick_vector.sv]
`timescale 1ns / 100ps
// testbench top: drives touch events and register writes into the joystick block
module tb_touch_joystick_vector;
  import tjv_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;  // no register behind this index

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [63:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_data;
  int          fail_count;
  int          pending;

  int gap_pct   = 0;
  int stall_pct = 0;
  int cur_cx;
  int cur_cy;
  int cur_mt;
  int cur_kr;

  touch_joystick_vector dut (.*);

  touch_joystick_vector_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [11:0] clip_coord(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return v[11:0];
  endfunction

  function automatic int spread(input int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin gap_pct = 0;  stall_pct = 0;  end
      1:       begin gap_pct = 76; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 76; end
      default: begin gap_pct = 25; stall_pct = 25; end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_event(input tjv_event_t kind, input logic [11:0] tx,
                            input logic [11:0] ty);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {ty, tx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every report is back, then let a silent event finish
  task automatic settle(input int extra);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_config(input int cx, input int cy, input int mt, input int kr,
                            input int id);
    settle(200);
    write_reg(REG_SPARE, 12'($urandom_range(4095)));
    write_reg(REG_CENTER_X, 12'(cx));
    write_reg(REG_CENTER_Y, 12'(cy));
    // unused upper bits get random values
    write_reg(REG_MAX_TRAVEL, {1'($urandom_range(1)), 11'(mt)});
    write_reg(REG_KNOB_RADIUS, {1'($urandom_range(1)), 11'(kr)});
    write_reg(REG_STICK_ID, {4'($urandom_range(15)), 8'(id)});
    cfg_valid <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
    cur_mt = mt;
    cur_kr = kr;
  endtask

  task automatic send_drag();
    int sel;
    int r;
    int eff;
    sel = $urandom_range(99);
    eff = (cur_mt == 0) ? 1 : cur_mt;
    if (sel < 40) r = eff;
    else if (sel < 70) r = 2 * eff + 8;
    else if (sel < 80) r = eff / 100;
    else r = 4095;
    send_event(EV_DRAG, clip_coord(cur_cx + spread(r)), clip_coord(cur_cy + spread(r)));
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int steps;
    int g;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        // press mostly inside the grab zone, then a drag run and usually a release
        g = (cur_kr * 3 / 2) * 7 / 10;
        if ($urandom_range(99) < 80)
          send_event(EV_PRESS, clip_coord(cur_cx + spread(g)), clip_coord(cur_cy + spread(g)));
        else
          send_event(EV_PRESS, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        steps = $urandom_range(1, 12);
        repeat (steps) send_drag();
        if ($urandom_range(9) != 0)
          send_event(EV_RELEASE, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        sent = sent + steps + 2;
      end else begin
        send_event(tjv_event_t'($urandom_range(3)), 12'($urandom_range(4095)),
                   12'($urandom_range(4095)));
        sent = sent + 1;
      end
      if ($urandom_range(99) < 3) settle(0);
    end
  endtask

  initial begin
    int phase;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = EV_OTHER;
    cfg_valid = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data  = '0;
    cur_cx    = 0;
    cur_cy    = 0;
    cur_mt    = 1;
    cur_kr    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register values straight out of reset: center at origin, unit travel
    send_event(EV_RELEASE, 12'd0, 12'd0);
    send_event(EV_PRESS, 12'd0, 12'd0);
    send_event(EV_DRAG, 12'd4095, 12'd4095);  // clamps to zero, too small
    send_event(EV_DRAG, 12'd4095, 12'd0);     // full right, ratio saturates
    send_event(EV_OTHER, 12'd4095, 12'd4095);

    set_config(2048, 2048, 100, 40, 8'hA5);
    send_event(EV_RELEASE, 12'd2048, 12'd2048);
    send_event(EV_DRAG, 12'd2100, 12'd2100);  // not grabbed, ignored
    send_event(EV_PRESS, 12'd2048, 12'd2048);
    send_event(EV_DRAG, 12'd2098, 12'd2018);
    send_event(EV_DRAG, 12'd2048, 12'd2048);  // tiny move, no word
    send_event(EV_DRAG, 12'd2049, 12'd2048);  // just at the tiny-move threshold
    send_event(EV_DRAG, 12'd4095, 12'd4095);
    send_event(EV_DRAG, 12'd0, 12'd0);
    send_event(EV_DRAG, 12'd2248, 12'd2048);  // full right
    send_event(EV_DRAG, 12'd2048, 12'd2248);  // full down
    send_event(EV_DRAG, 12'd2048, 12'd1848);  // full up
    send_event(EV_DRAG, 12'd1848, 12'd2048);  // full left
    send_event(EV_OTHER, 12'd2048, 12'd2048);
    send_event(EV_RELEASE, 12'd0, 12'd4095);
    send_event(EV_PRESS, 12'd2109, 12'd2048); // just outside the grab zone
    send_event(EV_DRAG, 12'd2060, 12'd2060);
    send_event(EV_PRESS, 12'd2108, 12'd2048); // on the grab zone edge
    send_event(EV_DRAG, 12'd2108, 12'd2048);
    send_event(EV_RELEASE, 12'd2048, 12'd2048);

    // zero travel acts as one
    set_config(2048, 2048, 0, 40, 8'h5A);
    send_event(EV_PRESS, 12'd2048, 12'd2048);
    send_event(EV_DRAG, 12'd2049, 12'd2048);
    send_event(EV_DRAG, 12'd2051, 12'd2052);
    send_event(EV_RELEASE, 12'd2048, 12'd2048);

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config($urandom_range(512, 3583), $urandom_range(512, 3583),
                      $urandom_range(16, 400), $urandom_range(8, 200), $urandom_range(255));
        1: set_config(0, 0, 2047, 2047, 255);
        2: set_config(4095, 4095, 1, 0, 0);
        3: set_config($urandom_range(4095), $urandom_range(4095), $urandom_range(1, 2047),
                      $urandom_range(2047), $urandom_range(255));
        default: set_config($urandom_range(4095), $urandom_range(4095),
                            $urandom_range(2, 64), $urandom_range(2, 64), $urandom_range(255));
      endcase
      set_idling(phase % 4);
      run_phase(170);
    end

    settle(200);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
